>>> design/gbfd_pkg.sv
// ----------------------------------------------------------------------------
// gbfd_pkg
// shared types and constants of the binary frame deframer
// ----------------------------------------------------------------------------
package gbfd_pkg;

   localparam int unsigned STAT_W = 16;

   localparam logic [7:0] SYNC_ONE  = 8'hB5;
   localparam logic [7:0] SYNC_TWO  = 8'h62;
   localparam logic [7:0] CLASS_NAV = 8'h01;
   localparam logic [7:0] ID_RELPOS = 8'h3C;
   localparam logic [7:0] CLASS_RXM = 8'h02;
   localparam logic [7:0] ID_CORR   = 8'h32;

   localparam logic [15:0] SOL_BYTE_INDEX  = 16'd60;
   localparam logic [15:0] CORR_BYTE_INDEX = 16'd1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_CHK_ERR = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        payload_byte;
      logic [15:0]       payload_index;
      logic [7:0]        frame_class;
      logic [7:0]        frame_id;
      logic [15:0]       frame_length;
      logic              last_payload;
      logic [1:0]        solution_type;
      logic [STAT_W-1:0] checksum_errors;
      logic [STAT_W-1:0] correction_packets;
      logic [STAT_W-1:0] correction_errors;
   } result_type;

endpackage

>>> design/gnss_binary_frame_deframer.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_deframer
// deframer for sync-prefixed binary frames with an 8-bit fletcher checksum
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and gives a transfer for every payload
// byte and for every checksum verdict; sync, header and ignored bytes give
// none. A byte passes from its input transfer into the input register and then
// through the parser into the result register.
// One byte can be taken in every cycle; the input register holds one more
// byte while a result waits in the result register, so a stalled result side
// blocks the input only once both registers are full. Counters are
// COUNTER_BITS wide, wrap, and are shown as their low sixteen bits.
module gnss_binary_frame_deframer #(
   parameter int COUNTER_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // payload_byte, payload_index, frame_class,
                                     // frame_id, frame_length, solution_type,
                                     // checksum_errors, correction_packets,
                                     // correction_errors, zero fill
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast    // last_payload
);
   import gbfd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_xfer;
   logic       step;
   logic       has_result;
   logic       out_free;
   result_type parse_result;
   result_type out_data;

   assign req_xfer    = req_tvalid && req_tready;
   assign step        = in_valid_ff && (!has_result || out_free);
   assign req_tready  = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
   end

   gbfd_parser #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .has_result (has_result),
      .result     (parse_result)
   );

   gbfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && has_result),
      .load_data (parse_result),
      .take      (rsp_tready),
      .free      (out_free),
      .valid     (rsp_tvalid),
      .data      (out_data)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last_payload;
   assign rsp_tdata = {6'd0,
                       out_data.correction_errors,
                       out_data.correction_packets,
                       out_data.checksum_errors,
                       out_data.solution_type,
                       out_data.frame_length,
                       out_data.frame_id,
                       out_data.frame_class,
                       out_data.payload_index,
                       out_data.payload_byte};

endmodule

>>> design/gbfd_parser.sv
// ----------------------------------------------------------------------------
// gbfd_parser
// frame state machine, fletcher checksum, solution capture and counters
// ----------------------------------------------------------------------------
module gbfd_parser #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 has_result,
   output gbfd_pkg::result_type result
);
   import gbfd_pkg::*;

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LENLO   = 4'd4,
      PH_LENHI   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CKA     = 4'd7,
      PH_CKB     = 4'd8
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [7:0]              sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [7:0]              sum_a_add, sum_b_add;
   logic [7:0]              class_ff, class_in, id_ff, id_in;
   logic [15:0]             length_ff, length_in, count_ff, count_in, count_inc;
   logic [1:0]              pend_sol_ff, pend_sol_in, sol_ff, sol_in;
   logic                    pend_cerr_ff, pend_cerr_in;
   logic [COUNTER_BITS-1:0] chk_err_ff, chk_err_in;
   logic [COUNTER_BITS-1:0] corr_pkt_ff, corr_pkt_in;
   logic [COUNTER_BITS-1:0] corr_err_ff, corr_err_in;
   logic [STAT_W-1:0]       chk_err_view, corr_pkt_view, corr_err_view;
   logic [1:0]              kind;
   logic                    last;
   logic                    is_relpos_hdr, is_corr_hdr;

   assign sum_a_add     = sum_a_ff + rx_byte;
   assign sum_b_add     = sum_b_ff + sum_a_add;
   assign count_inc     = count_ff + 16'd1;
   assign is_relpos_hdr = (class_ff == CLASS_NAV) && (id_ff == ID_RELPOS);
   assign is_corr_hdr   = (class_ff == CLASS_RXM) && (id_ff == ID_CORR);

   always_comb begin
      phase_in     = phase_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      class_in     = class_ff;
      id_in        = id_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      pend_sol_in  = pend_sol_ff;
      pend_cerr_in = pend_cerr_ff;
      sol_in       = sol_ff;
      chk_err_in   = chk_err_ff;
      corr_pkt_in  = corr_pkt_ff;
      corr_err_in  = corr_err_ff;
      has_result   = 1'b0;
      kind         = KIND_PAYLOAD;
      last         = 1'b0;
      case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == SYNC_TWO) begin
               phase_in     = PH_CLASS;
               sum_a_in     = 8'd0;
               sum_b_in     = 8'd0;
               pend_sol_in  = 2'd0;
               pend_cerr_in = 1'b0;
            end
         end
         PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            phase_in  = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = {rx_byte, length_ff[7:0]};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            count_in  = 16'd0;
            phase_in  = (length_in == 16'd0) ? PH_CKA : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            if (is_relpos_hdr && (count_ff == SOL_BYTE_INDEX)) begin
               pend_sol_in = rx_byte[4:3];
            end
            if (is_corr_hdr && (count_ff == CORR_BYTE_INDEX)) begin
               pend_cerr_in = rx_byte[0];
            end
            count_in   = count_inc;
            last       = (count_inc >= length_ff);
            has_result = 1'b1;
            kind       = KIND_PAYLOAD;
            if (last) begin
               phase_in = PH_CKA;
            end
         end
         PH_CKA: begin
            if (rx_byte == sum_a_ff) begin
               phase_in = PH_CKB;
            end else begin
               phase_in   = PH_SYNC1;
               chk_err_in = chk_err_ff + 1'b1;
               has_result = 1'b1;
               kind       = KIND_CHK_ERR;
            end
         end
         PH_CKB: begin
            phase_in   = PH_SYNC1;
            has_result = 1'b1;
            if (rx_byte != sum_b_ff) begin
               chk_err_in = chk_err_ff + 1'b1;
               kind       = KIND_CHK_ERR;
            end else begin
               kind = KIND_GOOD;
               if (is_relpos_hdr) begin
                  sol_in = pend_sol_ff;
               end
               if (is_corr_hdr) begin
                  corr_pkt_in = corr_pkt_ff + 1'b1;
                  if (pend_cerr_ff) begin
                     corr_err_in = corr_err_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            phase_in = (rx_byte == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
   end

   // counters show as their low bits, zero-filled when narrow
   if (COUNTER_BITS >= STAT_W) begin : g_wide_cnt
      assign chk_err_view  = chk_err_in[STAT_W-1:0];
      assign corr_pkt_view = corr_pkt_in[STAT_W-1:0];
      assign corr_err_view = corr_err_in[STAT_W-1:0];
   end else begin : g_narrow_cnt
      assign chk_err_view  = {{(STAT_W-COUNTER_BITS){1'b0}}, chk_err_in};
      assign corr_pkt_view = {{(STAT_W-COUNTER_BITS){1'b0}}, corr_pkt_in};
      assign corr_err_view = {{(STAT_W-COUNTER_BITS){1'b0}}, corr_err_in};
   end

   always_comb begin
      result.kind               = kind;
      result.payload_byte       = (kind == KIND_PAYLOAD) ? rx_byte : 8'd0;
      result.payload_index      = (kind == KIND_PAYLOAD) ? count_ff : 16'd0;
      result.frame_class        = class_in;
      result.frame_id           = id_in;
      result.frame_length       = length_in;
      result.last_payload       = last;
      result.solution_type      = sol_in;
      result.checksum_errors    = chk_err_view;
      result.correction_packets = corr_pkt_view;
      result.correction_errors  = corr_err_view;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         class_ff     <= 8'd0;
         id_ff        <= 8'd0;
         length_ff    <= 16'd0;
         count_ff     <= 16'd0;
         pend_sol_ff  <= 2'd0;
         pend_cerr_ff <= 1'b0;
         sol_ff       <= 2'd0;
         chk_err_ff   <= '0;
         corr_pkt_ff  <= '0;
         corr_err_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         class_ff     <= class_in;
         id_ff        <= id_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         pend_sol_ff  <= pend_sol_in;
         pend_cerr_ff <= pend_cerr_in;
         sol_ff       <= sol_in;
         chk_err_ff   <= chk_err_in;
         corr_pkt_ff  <= corr_pkt_in;
         corr_err_ff  <= corr_err_in;
      end
   end

   // a verdict always sends the parser back to hunting
   a_verdict_rehunt: assert property (@(posedge clock) disable iff (reset)
      step && has_result && (kind != KIND_PAYLOAD) |=> phase_ff == PH_SYNC1)
      else $error("verdict did not return to sync hunt");

   a_chk_err_count: assert property (@(posedge clock) disable iff (reset)
      step && has_result && (kind == KIND_CHK_ERR)
      |=> chk_err_ff == COUNTER_BITS'($past(chk_err_ff) + 1'b1))
      else $error("checksum error not counted");

   a_corr_err_with_pkt: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (corr_err_ff != $past(corr_err_ff))
      |-> corr_pkt_ff != $past(corr_pkt_ff))
      else $error("correction error counted without a packet");

   a_payload_last_only: assert property (@(posedge clock) disable iff (reset)
      has_result && (kind != KIND_PAYLOAD) |-> !last)
      else $error("last flag on a verdict");

endmodule

>>> design/gbfd_out_reg.sv
// ----------------------------------------------------------------------------
// gbfd_out_reg
// result register between the parser and the result channel
// ----------------------------------------------------------------------------
module gbfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  gbfd_pkg::result_type load_data,
   input  logic                 take,
   output logic                 free,
   output logic                 valid,
   output gbfd_pkg::result_type data
);
   import gbfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free  = !valid_ff || take;
   assign valid = valid_ff;
   assign data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
